// ----- rtl/sioq_pkg.sv -----
`default_nettype none

package sioq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_REL     = 16;
  localparam int PROC_W      = 8;
  localparam int TIME_W      = 20;
  localparam int BURST_W     = 16;
  localparam int REL_CNT_W   = $clog2(MAX_REL);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_RELEASED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [PROC_W-1:0] proc_id;
    logic [TIME_W-1:0] ret_time;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_REL
  } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/sioq_cell.sv -----
`default_nettype none

module sioq_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sioq_pkg::cell_ctrl_t ctrl,
  input  sioq_pkg::entry_t     new_entry,
  input  wire                  left_keep,
  input  sioq_pkg::entry_t     left_entry,
  input  wire                  left_vld,
  input  sioq_pkg::entry_t     right_entry,
  input  wire                  right_vld,
  output sioq_pkg::entry_t     entry,
  output logic                 vld,
  output logic                 keep
);
  import sioq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   vld_r, vld_nxt;

  // keep: occupied and due no later than the new entry
  assign keep  = vld_r && (entry_r.ret_time <= new_entry.ret_time);
  assign entry = entry_r;
  assign vld   = vld_r;

  always_comb begin
    entry_nxt = entry_r;
    vld_nxt   = vld_r;
    if (ctrl.ins && !keep) begin
      if (left_keep) begin
        entry_nxt = new_entry;
        vld_nxt   = 1'b1;
      end else begin
        entry_nxt = left_entry;
        vld_nxt   = left_vld;
      end
    end else if (ctrl.shl) begin
      entry_nxt = right_entry;
      vld_nxt   = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_io_wait_timer_queue.sv -----
`default_nettype none

// Sorted I/O wait queue built as a row of cells, front at cell 0, held in
// return-time order (ties keep arrival order). An add beat is taken when
// the result register is free: the return time now_time + burst_time
// (saturated) is compared in every cell at once and the row opens a gap in
// that cycle; one result beat answers it (added, or dropped when all cells
// are full). A check beat then releases, one beat per cycle while the result
// register is free (low out_tready stalls it), each front entry whose return
// time equals now_time, up to 16 per check, the last marked by out_tlast; a
// check that finds nothing due gives no beat. No new input beat is taken
// while a check is releasing, so a check holds the input until its due
// entries have been released (or it finds nothing due), and also while
// out_tready is low.
module sorted_io_wait_timer_queue (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // proc_id[7:0], now_time[27:8], burst_time[43:28], zero
  input  wire         in_tuser,   // kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // out_proc_id[7:0], ret_time[27:8], zero
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);
  import sioq_pkg::*;

  fsm_t state_r, state_nxt;

  logic [PROC_W-1:0]    in_proc;
  logic [TIME_W-1:0]    in_now;
  logic [BURST_W-1:0]   in_burst;
  logic [TIME_W:0]      sum;
  entry_t               new_entry;
  logic                 in_acc;

  logic [TIME_W-1:0]    now_r;
  logic [REL_CNT_W-1:0] cnt_r, cnt_nxt;

  entry_t               cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_vld;
  logic [QUEUE_DEPTH-1:0] cell_keep;
  cell_ctrl_t           ctrl;

  logic                 out_free;
  logic                 due;
  logic                 rel_last;

  logic                 out_vld_r;
  entry_t               out_entry_r, out_entry_nxt;
  logic [1:0]           out_st_r, out_st_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;

  assign in_proc  = in_tdata[PROC_W-1:0];
  assign in_now   = in_tdata[PROC_W +: TIME_W];
  assign in_burst = in_tdata[PROC_W+TIME_W +: BURST_W];

  assign sum = {1'b0, in_now} + {{(TIME_W+1-BURST_W){1'b0}}, in_burst};
  assign new_entry.proc_id  = in_proc;
  assign new_entry.ret_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign due      = cell_vld[0] && (cell_entry[0].ret_time == now_r);
  assign rel_last = !(cell_vld[1] && (cell_entry[1].ret_time == now_r)) ||
                    (cnt_r == REL_CNT_W'(MAX_REL - 1));

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      sioq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .left_keep  ((gi == 0) ? 1'b1 : cell_keep[(gi == 0) ? 0 : gi-1]),
        .left_entry (cell_entry[(gi == 0) ? 0 : gi-1]),
        .left_vld   ((gi == 0) ? 1'b0 : cell_vld[(gi == 0) ? 0 : gi-1]),
        .right_entry(cell_entry[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .right_vld  ((gi == QUEUE_DEPTH-1) ? 1'b0 :
                     cell_vld[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .entry      (cell_entry[gi]),
        .vld        (cell_vld[gi]),
        .keep       (cell_keep[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == KIND_CHECK)) begin
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        if (!due || (out_free && rel_last)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    out_load      = 1'b0;
    out_entry_nxt = out_entry_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && (in_tuser == KIND_ADD)) begin
          ctrl.ins      = !cell_vld[QUEUE_DEPTH-1];
          out_load      = 1'b1;
          out_entry_nxt = new_entry;
          out_st_nxt    = cell_vld[QUEUE_DEPTH-1] ? ST_FULL : ST_ADDED;
          out_last_nxt  = 1'b1;
        end
      end
      S_REL: begin
        if (due && out_free) begin
          ctrl.shl      = 1'b1;
          out_load      = 1'b1;
          out_entry_nxt = cell_entry[0];
          out_st_nxt    = ST_RELEASED;
          out_last_nxt  = rel_last;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_now;
    end
    if (out_load) begin
      out_entry_r <= out_entry_nxt;
      out_st_r    <= out_st_nxt;
      out_last_r  <= out_last_nxt;
    end
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(32-PROC_W-TIME_W){1'b0}}, out_entry_r.ret_time, out_entry_r.proc_id};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_occupancy_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld >> 1) & ~cell_vld) == '0)
    else $error("occupied cells not contiguous from the front");

  a_full_drop_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == KIND_ADD) && cell_vld[QUEUE_DEPTH-1]) |=> $stable(cell_vld))
    else $error("dropped add changed the row");

  a_no_intake_while_releasing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL) |-> !in_tready)
    else $error("input taken during release");

  a_add_answer_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_st_r != ST_RELEASED)) |-> out_last_r)
    else $error("add answer not marked last");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_sorted_io_wait_timer_queue.sv -----
`timescale 1ns / 1ps

module tb_sorted_io_wait_timer_queue;
  import sioq_pkg::*;

  localparam int N_RANDOM   = 360;
  localparam int QUIET_TAIL = 40;
  localparam int HOLD_EP    = 3;

  typedef struct packed {
    logic              kind;
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] now;
    logic [BURST_W-1:0] burst;
    logic              hold;   // wait for all results before presenting
  } wait_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] rt;
    logic              last;
  } wait_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [31:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  wait_req_t   req_q[$];
  wait_res_t   due_results[$];
  wait_req_t   cur_beat = '0;
  logic        in_fire = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          errors = 0;
  logic        hold_next = 1'b0;

  entry_t      wq_store[QUEUE_DEPTH];
  int          wq_count = 0;

  logic [TIME_W-1:0] sweep_times[$];

  sorted_io_wait_timer_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] t,
                                                input logic [BURST_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, t} + b;
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // shadow queue: insert after equal times, release due run from the front
  task automatic wait_queue_step(input wait_req_t r);
    logic [TIME_W-1:0] rt;
    int pos;
    int n;
    int i;
    if (r.kind == KIND_ADD) begin
      rt = sat_sum(r.now, r.burst);
      if (wq_count >= QUEUE_DEPTH) begin
        due_results.push_back('{ST_FULL, r.proc, rt, 1'b1});
      end else begin
        pos = 0;
        while (pos < wq_count && wq_store[pos].ret_time <= rt) pos++;
        for (i = wq_count; i > pos; i--) wq_store[i] = wq_store[i-1];
        wq_store[pos] = {r.proc, rt};
        wq_count++;
        due_results.push_back('{ST_ADDED, r.proc, rt, 1'b1});
      end
    end else begin
      n = 0;
      while (n < wq_count && n < MAX_REL && wq_store[n].ret_time == r.now) n++;
      for (i = 0; i < n; i++)
        due_results.push_back('{ST_RELEASED, wq_store[i].proc_id, wq_store[i].ret_time,
                                (i == n - 1)});
      for (i = n; i < wq_count; i++) wq_store[i-n] = wq_store[i];
      wq_count -= n;
    end
  endtask

  task automatic push_add(input int p, input int t, input int b);
    req_q.push_back('{KIND_ADD, p[PROC_W-1:0], t[TIME_W-1:0], b[BURST_W-1:0], hold_next});
    hold_next = 1'b0;
  endtask

  task automatic push_check(input int t);
    req_q.push_back('{KIND_CHECK, 8'($urandom), t[TIME_W-1:0], 16'($urandom), hold_next});
    hold_next = 1'b0;
  endtask

  task automatic note_time(input logic [TIME_W-1:0] t);
    int j;
    j = 0;
    while (j < sweep_times.size() && sweep_times[j] < t) j++;
    if (j == sweep_times.size() || sweep_times[j] != t) sweep_times.insert(j, t);
  endtask

  // driver
  always @(negedge clk) begin : drv
    logic v;
    wait_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      v = in_tvalid;
      if (in_tvalid && in_fire) v = 1'b0;
      if (!v) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (req_q.size() > 0 && (!req_q[0].hold || due_results.size() == 0)) begin
          nxt = req_q.pop_front();
          cur_beat <= nxt;
          in_tdata <= {4'b0, nxt.burst, nxt.now, nxt.proc};
          in_tuser <= nxt.kind;
          v = 1'b1;
          if (req_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            in_gap <= $urandom_range(1, 11);
        end
      end
      in_tvalid <= v;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (req_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        out_stall <= $urandom_range(1, 11);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    wait_res_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got st %0d id %0h rt %0h last %0b",
                   $time, out_tuser, out_tdata[7:0], out_tdata[27:8], out_tlast);
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status || out_tdata[7:0] !== want.proc ||
              out_tdata[27:8] !== want.rt || out_tlast !== want.last) begin
            errors++;
            $display("%0t: mismatch, expected st %0d id %0h rt %0h last %0b, got st %0d id %0h rt %0h last %0b",
                     $time, want.status, want.proc, want.rt, want.last,
                     out_tuser, out_tdata[7:0], out_tdata[27:8], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) wait_queue_step(cur_beat);
    end
  end

  initial begin
    int i;
    int ep;
    int k;
    int n_add;
    int tgt;
    int p;
    int t;
    int b;
    logic top;
    logic [TIME_W-1:0] base;

    // directed
    push_check(0);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0: push_add(0, TIME_MAX, 0);
        1: push_add(255, TIME_MAX, 16'hFFFF);
        2: push_add(8'h5A, 20'hFFFF0, 16'h0020);
        3: push_add(8'hC3, TIME_MAX - 16'hFFFF, 16'hFFFF);
        default: push_add(i * 17, TIME_MAX - i, 3 * i);
      endcase
    end
    push_add(8'hA5, 0, 0);
    push_check(TIME_MAX - 1);
    push_check(TIME_MAX);
    push_add(1, 90, 10);
    push_add(0, 0, 0);
    push_add(2, 100, 0);
    push_check(0);
    push_check(100);

    // random episodes: adds clustered near a base time with some checks mixed in, then an ascending sweep
    ep = 0;
    while (req_q.size() < N_RANDOM) begin
      sweep_times.delete();
      top = ($urandom_range(0, 5) == 0);
      base = top ? TIME_MAX - $urandom_range(0, 3) : $urandom_range(0, TIME_MAX);
      n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      if (ep == HOLD_EP) hold_next = 1'b1;
      for (k = 0; k < n_add; k++) begin
        p = $urandom_range(0, 255);
        b = $urandom_range(0, 65535);
        if ($urandom_range(0, 9) == 0) begin
          t = $urandom_range(0, TIME_MAX);
        end else if (top) begin
          t = TIME_MAX - $urandom_range(0, 255);
        end else begin
          tgt = base + $urandom_range(0, 3);
          if (tgt > TIME_MAX) tgt = TIME_MAX;
          if (b > tgt) b = tgt;
          t = tgt - b;
        end
        push_add(p, t, b);
        note_time(sat_sum(t[TIME_W-1:0], b[BURST_W-1:0]));
        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0)
            push_check($urandom_range(0, TIME_MAX));
          else
            push_check(sweep_times[$urandom_range(0, sweep_times.size() - 1)]);
        end
      end
      foreach (sweep_times[j]) push_check(sweep_times[j]);
      if ($urandom_range(0, 3) == 0) push_check($urandom_range(0, TIME_MAX));
      ep++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    wait (req_q.size() == 0 && !in_tvalid);
    wait (due_results.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_sorted_io_wait_timer_queue OK");
    end else begin
      $display("tb_sorted_io_wait_timer_queue NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_sorted_io_wait_timer_queue NOT OK");
    $finish;
  end

endmodule
